// ===== design/text_mode_terminal_writer_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TMTW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TMTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tmtw_pkg.sv =====
`timescale 1ns / 1ps

package tmtw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

	localparam int TAB_STEP = 8;

endpackage

// ===== design/text_mode_terminal_writer_unit.sv =====
// Put, read and no-op items: result registered from EXEC, or from DONE under out_stall;
// one item at a time (accept, then the cell store's registered read or write).
// Clear and scrolling puts walk all COLUMNS*ROWS cells through the single write port.
// Reset: cursor home, attribute 0x0F; a clearing pass over all COLUMNS*ROWS cells blanks the
// store while in_stall stays high. Configuration writes are taken at any time.
`timescale 1ns / 1ps

module text_mode_terminal_writer_unit #(
	parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tmtw_pkg::FUNC_W-1:0] func,
	input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
	input  logic [tmtw_pkg::POS_W-1:0]  cell_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tmtw_pkg::POS_W-1:0]  cursor_position,
	output logic [tmtw_pkg::CELL_W-1:0] cell_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tmtw_pkg::ATTR_W-1:0] text_attribute
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_waddr;
	logic [tmtw_pkg::CELL_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [ADDR_W-1:0]           mem_raddr;
	logic [tmtw_pkg::CELL_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	tmtw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.ADDR_W  (ADDR_W)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cursor_position (cursor_position),
		.cell_data       (cell_data),
		.cfg_valid       (cfg_valid),
		.text_attribute  (text_attribute),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_re          (mem_re),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata)
	);

	tmtw_cells #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (ADDR_W)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== design/tmtw_cells.sv =====
`timescale 1ns / 1ps

module tmtw_cells #(
	parameter int DEPTH  = tmtw_pkg::COLUMNS_DEF * tmtw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [tmtw_pkg::CELL_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [tmtw_pkg::CELL_W-1:0] rdata
);

	logic [tmtw_pkg::CELL_W-1:0] mem [DEPTH];
	logic [tmtw_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tmtw_ctrl.sv =====
`timescale 1ns / 1ps

module tmtw_ctrl #(
	parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmtw_pkg::ROWS_DEF,
	parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tmtw_pkg::FUNC_W-1:0] func,
	input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
	input  logic [tmtw_pkg::POS_W-1:0]  cell_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tmtw_pkg::POS_W-1:0]  cursor_position,
	output logic [tmtw_pkg::CELL_W-1:0] cell_data,
	input  logic                        cfg_valid,
	input  logic [tmtw_pkg::ATTR_W-1:0] text_attribute,
	output logic                        mem_we,
	output logic [ADDR_W-1:0]           mem_waddr,
	output logic [tmtw_pkg::CELL_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [ADDR_W-1:0]           mem_raddr,
	input  logic [tmtw_pkg::CELL_W-1:0] mem_rdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                  state_q;
	logic [tmtw_pkg::FUNC_W-1:0] func_q;
	logic [tmtw_pkg::CHAR_W-1:0] ch_q;
	logic                        idx_ok_q;
	logic [COL_W-1:0]            col_q;
	logic [ROW_W-1:0]            row_q;
	logic [tmtw_pkg::ATTR_W-1:0] attr_q;
	logic [ADDR_W-1:0]           sweep_q;
	logic                        clr_q;
	logic                        report_q;
	logic [tmtw_pkg::CELL_W-1:0] data_q;

	logic                        wv_s1;
	logic [ADDR_W-1:0]           waddr_s1;
	logic                        blank_s1;

	logic                        out_valid_q;
	logic [tmtw_pkg::POS_W-1:0]  out_pos_q;
	logic [tmtw_pkg::CELL_W-1:0] out_data_q;

	logic [COL_W:0]              col_t;
	logic [ROW_W:0]              row_t;
	logic [COL_W-1:0]            col_n;
	logic [ROW_W-1:0]            row_n;
	logic                        print;
	logic                        scroll;
	logic [tmtw_pkg::POS_W-1:0]  pos_n;
	logic [ADDR_W-1:0]           print_addr;
	logic [tmtw_pkg::CELL_W-1:0] exec_data;
	logic                        accept;
	logic                        idx_ok;
	logic                        copy;
	logic                        slot_free;
	logic                        load;
	logic                        sweep_last;

	assign accept    = in_valid && !in_stall;
	assign idx_ok    = 32'(cell_index) < CELL_COUNT;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	// Cursor update of a put or a clear, wrap and scroll included.
	always_comb begin
		col_t  = {1'b0, col_q};
		row_t  = {1'b0, row_q};
		print  = 1'b0;
		scroll = 1'b0;
		if (state_q == ST_EXEC && func_q == tmtw_pkg::FN_PUT) begin
			if (ch_q == tmtw_pkg::CH_BS) begin
				if (col_q != '0) begin
					col_t = col_t - 1'b1;
				end
			end else if (ch_q == tmtw_pkg::CH_TAB) begin
				col_t = (col_t + (COL_W+1)'(tmtw_pkg::TAB_STEP))
					& ~(COL_W+1)'(tmtw_pkg::TAB_STEP - 1);
			end else if (ch_q == tmtw_pkg::CH_CR) begin
				col_t = '0;
			end else if (ch_q == tmtw_pkg::CH_LF) begin
				col_t = '0;
				row_t = row_t + 1'b1;
			end else if (ch_q >= tmtw_pkg::CH_SPACE && ch_q <= tmtw_pkg::CH_LAST) begin
				print = 1'b1;
				col_t = col_t + 1'b1;
			end
			if (col_t >= (COL_W+1)'(COLUMNS)) begin
				col_t = '0;
				row_t = row_t + 1'b1;
			end
			if (row_t >= (ROW_W+1)'(ROWS)) begin
				row_t  = (ROW_W+1)'(ROWS - 1);
				scroll = 1'b1;
			end
		end else if (state_q == ST_EXEC && func_q == tmtw_pkg::FN_CLEAR) begin
			col_t = '0;
			row_t = '0;
		end
	end

	assign col_n      = col_t[COL_W-1:0];
	assign row_n      = row_t[ROW_W-1:0];
	assign pos_n      = tmtw_pkg::POS_W'(32'(row_n) * COLUMNS + 32'(col_n));
	assign print_addr = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign exec_data  = (func_q == tmtw_pkg::FN_READ && idx_ok_q) ? mem_rdata : '0;

	// Sweep: copy phase reads one row ahead, the write lands in the next cycle.
	assign copy       = (state_q == ST_SWEEP) && !clr_q && (32'(sweep_q) < MOVE_COUNT);
	assign sweep_last = (32'(sweep_q) == CELL_COUNT - 1);

	assign load = slot_free && (
		(state_q == ST_EXEC && !scroll && func_q != tmtw_pkg::FN_CLEAR) ||
		(state_q == ST_DONE && report_q));

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = ADDR_W'(cell_index);
		if (state_q == ST_SWEEP) begin
			mem_re    = copy;
			mem_raddr = ADDR_W'(32'(sweep_q) + COLUMNS);
		end else if (accept && func == tmtw_pkg::FN_READ && idx_ok) begin
			mem_re = 1'b1;
		end
	end

	always_comb begin
		mem_we    = wv_s1 || print;
		mem_waddr = print_addr;
		mem_wdata = {attr_q, ch_q};
		if (wv_s1) begin
			mem_waddr = waddr_s1;
			mem_wdata = blank_s1 ? tmtw_pkg::BLANK_CELL : mem_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			clr_q    <= 1'b1;
			report_q <= 1'b0;
			sweep_q  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			attr_q   <= tmtw_pkg::ATTR_RESET;
			wv_s1    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				attr_q <= text_attribute;
			end
			wv_s1 <= (state_q == ST_SWEEP);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					col_q    <= col_n;
					row_q    <= row_n;
					report_q <= 1'b1;
					sweep_q  <= '0;
					if (scroll || func_q == tmtw_pkg::FN_CLEAR) begin
						clr_q   <= (func_q == tmtw_pkg::FN_CLEAR);
						state_q <= ST_SWEEP;
					end else if (load) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load || !report_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			ch_q     <= char_code;
			idx_ok_q <= idx_ok;
		end
		if (state_q == ST_EXEC) begin
			data_q <= exec_data;
		end
		waddr_s1 <= sweep_q;
		blank_s1 <= !copy;
		if (load) begin
			out_pos_q  <= pos_n;
			out_data_q <= (state_q == ST_EXEC) ? exec_data : data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = out_pos_q;
	assign cell_data       = out_data_q;

endmodule

// ===== design/tmtw_checker.sv =====
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_unit_macros.svh"

module tmtw_checker #(
	parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [tmtw_pkg::POS_W-1:0]  cursor_position,
	input logic [tmtw_pkg::CELL_W-1:0] cell_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;

	// A stalled result beat holds.
	`TMTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(cursor_position) && $stable(cell_data), "result beat changed under stall")

	// One item in flight: the beat after an accept is always stalled.
	`TMTW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"input taken while an item was in progress")

	// A new result only appears out of a busy cycle.
	`TMTW_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall),
		"result appeared without an item in progress")

	// Cursor stays on the screen.
	`TMTW_ASSERT_NOW(a_cursor_range, out_valid, 32'(cursor_position) < CELL_COUNT,
		"cursor position beyond the screen")

endmodule

bind text_mode_terminal_writer_unit tmtw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tmtw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.cursor_position (cursor_position),
	.cell_data       (cell_data)
);

// ===== test/tmtw_screen_checker.sv =====
`timescale 1ns / 1ps

module tmtw_screen_checker
	import tmtw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [POS_W-1:0]  cell_index,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [POS_W-1:0]  cursor_position,
	input  logic [CELL_W-1:0] cell_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ATTR_W-1:0] text_attribute,
	output int                fail_count,
	output int                pending,
	output int                scroll_count
);

	localparam int CELLS      = COLUMNS * ROWS;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 5;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CELL_W-1:0] data;
	} screen_result_t;

	logic [CELL_W-1:0] screen [CELLS];
	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_row;
	logic [ATTR_W-1:0] attr;
	screen_result_t    result_q [$];
	int                fails;
	int                scrolls;

	function automatic void blank_screen();
		foreach (screen[i])
			screen[i] = BLANK_CELL;
	endfunction

	// Advance the screen model by one item and return the result it should produce.
	function automatic screen_result_t apply_item(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
			logic [POS_W-1:0] idx);
		screen_result_t r;
		int col;
		int row;
		r.data = '0;
		col = cur_col;
		row = cur_row;
		if (f == FN_PUT) begin
			if (ch == CH_BS) begin
				if (col != 0)
					col--;
			end else if (ch == CH_TAB) begin
				col = (col + TAB_STEP) & ~(TAB_STEP - 1);
			end else if (ch == CH_CR) begin
				col = 0;
			end else if (ch == CH_LF) begin
				col = 0;
				row++;
			end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
				screen[row * COLUMNS + col] = {attr, ch};
				col++;
			end
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			if (row >= ROWS) begin
				for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
					screen[i] = BLANK_CELL;
				row = ROWS - 1;
				scrolls++;
			end
		end else if (f == FN_CLEAR) begin
			blank_screen();
			col = 0;
			row = 0;
		end else if (f == FN_READ) begin
			if (idx < CELLS)
				r.data = screen[idx];
		end
		cur_col = COL_W'(col);
		cur_row = ROW_W'(row);
		r.pos = POS_W'(row * COLUMNS + col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_result_t want;
		if (!arst_n) begin
			blank_screen();
			cur_col = '0;
			cur_row = '0;
			attr = ATTR_RESET;
			result_q.delete();
			fails = 0;
			scrolls = 0;
			fail_count <= 0;
			pending <= 0;
			scroll_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				attr = text_attribute;
			if (in_valid && !in_stall)
				result_q.push_back(apply_item(func, char_code, cell_index));
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORT)
						$display("%0t: result beat with nothing expected: pos %0d data %h",
							$realtime, cursor_position, cell_data);
				end else begin
					want = result_q.pop_front();
					if (cursor_position !== want.pos || cell_data !== want.data) begin
						fails++;
						if (fails <= MAX_REPORT)
							$display("%0t: mismatch: pos exp %0d got %0d, data exp %h got %h",
								$realtime, want.pos, cursor_position, want.data, cell_data);
					end
				end
			end
			fail_count <= fails;
			pending <= result_q.size();
			scroll_count <= scrolls;
		end
	end

endmodule

// ===== test/text_mode_terminal_writer_unit_tb.sv =====
`timescale 1ns / 1ps

module text_mode_terminal_writer_unit_tb;
	import tmtw_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 160;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 6;
	// worst case: every item walks the whole store, plus stalls and gaps
	localparam int CYCLE_LIMIT = (PHASES * PHASE_ITEMS + 40) * (CELLS + 3 + 64) * 4
		+ CELLS + HOLD_CYCLES;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FUNC_W-1:0] func = FN_PUT;
	logic [CHAR_W-1:0] char_code = '0;
	logic [POS_W-1:0]  cell_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [POS_W-1:0]  cursor_position;
	logic [CELL_W-1:0] cell_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ATTR_W-1:0] text_attribute = ATTR_RESET;

	int fail_count;
	int pending;
	int scroll_count;

	int  send_idle_pct = IDLE_PCT;
	int  recv_stall_pct = IDLE_PCT;
	bit  hold_request = 1'b0;
	int  n_put, n_clear, n_read, n_unused, n_attr;

	text_mode_terminal_writer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_position(cursor_position),
		.cell_data      (cell_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_attribute (text_attribute)
	);

	tmtw_screen_checker screen_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.char_code      (char_code),
		.cell_index     (cell_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cursor_position(cursor_position),
		.cell_data      (cell_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_attribute (text_attribute),
		.fail_count     (fail_count),
		.pending        (pending),
		.scroll_count   (scroll_count)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Offer one item and return at the edge that accepts the beat.
	task automatic offer(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
			input logic [POS_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_code <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (f)
			FN_PUT:   n_put++;
			FN_CLEAR: n_clear++;
			FN_READ:  n_read++;
			default:  n_unused++;
		endcase
	endtask

	// Attribute changes only once every outstanding result has come back.
	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		text_attribute <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_attr++;
	endtask

	initial begin
		logic [ATTR_W-1:0] phase_attr [PHASES];
		logic [FUNC_W-1:0] f;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  idx;
		int                r;
		phase_attr = '{8'h00, 8'hFF, 8'h00, 8'hA5, 8'h00, 8'h5A};
		phase_attr[2] = ATTR_W'($urandom_range(255));
		phase_attr[4] = ATTR_W'($urandom_range(255));

		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		set_attribute(8'h1E);
		// reads of a fresh screen, including indexes past the store
		offer(FN_READ, CHAR_W'($urandom_range(255)), 11'd0);
		offer(FN_READ, CHAR_W'($urandom_range(255)), 11'(CELLS - 1));
		offer(FN_READ, CHAR_W'($urandom_range(255)), 11'h7FF);
		// printable bounds, bytes that must be ignored, then a backspace and a carriage return
		offer(FN_PUT, 8'h41, POS_W'($urandom_range(2047)));
		offer(FN_PUT, CH_SPACE, POS_W'($urandom_range(2047)));
		offer(FN_PUT, CH_LAST, POS_W'($urandom_range(2047)));
		offer(FN_PUT, 8'h80, POS_W'($urandom_range(2047)));
		offer(FN_PUT, 8'hFF, POS_W'($urandom_range(2047)));
		offer(FN_PUT, 8'h00, POS_W'($urandom_range(2047)));
		offer(FN_PUT, 8'h1F, POS_W'($urandom_range(2047)));
		offer(FN_PUT, CH_BS, POS_W'($urandom_range(2047)));
		offer(FN_PUT, CH_CR, POS_W'($urandom_range(2047)));
		// backspace at column zero does nothing
		offer(FN_PUT, CH_BS, POS_W'($urandom_range(2047)));
		// ten tabs from column zero run off the row and wrap
		repeat (10)
			offer(FN_PUT, CH_TAB, POS_W'($urandom_range(2047)));
		offer(FN_PUT, CH_LF, POS_W'($urandom_range(2047)));
		offer(FN_READ, CHAR_W'($urandom_range(255)), 11'd1);
		offer(FN_UNUSED, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
		offer(FN_CLEAR, CHAR_W'($urandom_range(255)), POS_W'($urandom_range(2047)));
		offer(FN_READ, CHAR_W'($urandom_range(255)), 11'd1);

		for (int p = 0; p < PHASES; p++) begin
			// one phase runs flat out, with no gaps on either side
			send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
			recv_stall_pct = (p == 2) ? 0 : IDLE_PCT;
			set_attribute(phase_attr[p]);
			if (p == 1)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS) begin
				f = FN_PUT;
				ch = CHAR_W'($urandom_range(255));
				idx = POS_W'($urandom_range(2047));
				r = $urandom_range(999);
				if (r < 3) begin
					f = FN_CLEAR;
				end else if (r < 13) begin
					f = FN_UNUSED;
				end else if (r < 100) begin
					f = FN_READ;
				end else begin
					// mostly text with line control; the rest keeps a raw byte
					r = $urandom_range(99);
					if (r < 72)
						ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
					else if (r < 80)
						ch = CH_LF;
					else if (r < 84)
						ch = CH_CR;
					else if (r < 88)
						ch = CH_TAB;
					else if (r < 93)
						ch = CH_BS;
				end
				offer(f, ch, idx);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (CELLS + 8) @(posedge clk);

		$display("Covered %0d puts, %0d clears, %0d reads, %0d unused selects, %0d scrolls",
			n_put, n_clear, n_read, n_unused, scroll_count);
		$display("Attribute settings: %0d, one %0d-cycle output hold-off under load",
			n_attr, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/tmtw_pkg.sv
design/tmtw_cells.sv
design/tmtw_ctrl.sv
design/text_mode_terminal_writer_unit.sv
design/tmtw_checker.sv
test/tmtw_screen_checker.sv
test/text_mode_terminal_writer_unit_tb.sv
